// ===== hw/rtl/ddg_pkg.sv =====
package ddg_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int IDX_W     = 6;
	localparam int HALF_W    = 64;
	localparam int DIGEST_W  = 2 * HALF_W;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_SCAN   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	localparam logic STATUS_MATCH = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;

endpackage

// ===== hw/rtl/ddg_req_if.sv =====
interface ddg_req_if;
	import ddg_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [HALF_W-1:0]   digest_high;
	logic [HALF_W-1:0]   digest_low;
	logic [IDX_W-1:0]    scan_index;

	modport source (output valid, mode, digest_high, digest_low, scan_index, input ready);
	modport sink   (input valid, mode, digest_high, digest_low, scan_index, output ready);
endinterface

// ===== hw/rtl/ddg_rsp_if.sv =====
interface ddg_rsp_if;
	import ddg_pkg::*;

	logic             valid;
	logic             ready;
	logic             status;
	logic [IDX_W-1:0] first_index;
	logic [IDX_W-1:0] match_index;
	logic             last;

	modport source (output valid, status, first_index, match_index, last, input ready);
	modport sink   (input valid, status, first_index, match_index, last, output ready);
endinterface

// ===== hw/rtl/ddg_ram.sv =====
module ddg_ram #(
	parameter int WIDTH = ddg_pkg::DIGEST_W,
	parameter int DEPTH = ddg_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/duplicate_digest_grouper.sv =====
// Table of up to DEPTH 128-bit digests held in two single-port-read memories
// (digest and valid mark), both with a registered read. An append to a full
// table returns one result with status full. A scan of entry h below the count
// reads the head entry; if it is valid, the later entries are read one per
// cycle from the memory read port while the result port does not stall, and
// compared against the head digest, and each equal valid entry is reported and
// its valid mark written back to zero. Each match is held until the next one
// is found or the scan ends, so the final one can be flagged last, and a stalled
// result port holds the scan. Clear only resets the fill count, so there is no
// clearing pass after reset and entries past the count are never read.
module duplicate_digest_grouper #(
	parameter int DEPTH = ddg_pkg::DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	ddg_req_if.sink   req,
	ddg_rsp_if.source rsp
);
	import ddg_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_SCAN} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rd_ptr_q;
	logic                cmp_vld_s1;
	logic [IW-1:0]       cmp_addr_s1;
	logic                pend_q;
	logic [IW-1:0]       pend_idx_q;
	logic [IW-1:0]       head_idx_q;
	logic [DIGEST_W-1:0] head_dig_q;

	logic                out_valid_q;
	logic                out_status_q;
	logic [IDX_W-1:0]    out_first_q;
	logic [IDX_W-1:0]    out_match_q;
	logic                out_last_q;

	logic                accept;
	logic                full;
	logic                out_can_load;
	logic [HW-1:0]       head_ext;
	logic                head_ok;
	logic                is_match;
	logic                emit_need;
	logic                stall;
	logic                more;
	logic                issue;
	logic                inval;
	logic                finish;

	logic                dig_we;
	logic [DIGEST_W-1:0] dig_rdata;
	logic                vld_we;
	logic                vld_wdata;
	logic [IW-1:0]       vld_waddr;
	logic                vld_rdata;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;

	assign out_can_load = !out_valid_q || rsp.ready;
	assign req.ready    = (state_q == ST_IDLE) && out_can_load;
	assign accept       = req.valid && req.ready;
	assign full         = (count_q == CW'(DEPTH));
	assign head_ext     = HW'(req.scan_index);
	assign head_ok      = head_ext < HW'(count_q);

	assign is_match  = cmp_vld_s1 && vld_rdata && (dig_rdata == head_dig_q);
	assign emit_need = is_match && pend_q;
	assign stall     = emit_need && !out_can_load;
	assign more      = rd_ptr_q < count_q;
	assign issue     = (state_q == ST_SCAN) && !stall && more;
	assign inval     = (state_q == ST_SCAN) && !stall && is_match;
	assign finish    = (state_q == ST_SCAN) && !cmp_vld_s1 && !more;

	assign dig_we = accept && (req.mode == MODE_APPEND) && !full;

	always_comb begin
		vld_we    = 1'b0;
		vld_wdata = 1'b0;
		vld_waddr = count_q[IW-1:0];
		if (dig_we) begin
			vld_we    = 1'b1;
			vld_wdata = 1'b1;
		end else if (inval) begin
			vld_we    = 1'b1;
			vld_waddr = cmp_addr_s1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q[IW-1:0];
		if (accept && (req.mode == MODE_SCAN) && head_ok) begin
			rd_en   = 1'b1;
			rd_addr = IW'(head_ext);
		end else if (issue) begin
			rd_en = 1'b1;
		end
	end

	ddg_ram #(.WIDTH(DIGEST_W), .DEPTH(DEPTH)) u_dig_ram (
		.clk   (clk),
		.we    (dig_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({req.digest_high, req.digest_low}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (dig_rdata)
	);

	ddg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vld_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (vld_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_addr_s1  <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			head_idx_q   <= '0;
			head_dig_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_MATCH;
			out_first_q  <= '0;
			out_match_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.mode)
							MODE_APPEND: begin
								if (full) begin
									out_valid_q  <= 1'b1;
									out_status_q <= STATUS_FULL;
									out_first_q  <= '0;
									out_match_q  <= '0;
									out_last_q   <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							MODE_SCAN: begin
								if (head_ok) begin
									head_idx_q <= IW'(head_ext);
									rd_ptr_q   <= CW'(head_ext) + CW'(1);
									cmp_vld_s1 <= 1'b0;
									pend_q     <= 1'b0;
									state_q    <= ST_HEAD;
								end
							end
							MODE_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_HEAD: begin
					head_dig_q <= dig_rdata;
					state_q    <= vld_rdata ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (!stall) begin
						cmp_vld_s1 <= issue;
						if (issue) begin
							cmp_addr_s1 <= rd_ptr_q[IW-1:0];
							rd_ptr_q    <= rd_ptr_q + CW'(1);
						end
						if (is_match) begin
							pend_q     <= 1'b1;
							pend_idx_q <= cmp_addr_s1;
						end
						// earlier match is now known not to be the final one
						if (emit_need) begin
							out_valid_q  <= 1'b1;
							out_status_q <= STATUS_MATCH;
							out_first_q  <= IDX_W'(head_idx_q);
							out_match_q  <= IDX_W'(pend_idx_q);
							out_last_q   <= 1'b0;
						end
					end
					if (finish) begin
						if (!pend_q) begin
							state_q <= ST_IDLE;
						end else if (out_can_load) begin
							out_valid_q  <= 1'b1;
							out_status_q <= STATUS_MATCH;
							out_first_q  <= IDX_W'(head_idx_q);
							out_match_q  <= IDX_W'(pend_idx_q);
							out_last_q   <= 1'b1;
							pend_q       <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.first_index = out_first_q;
	assign rsp.match_index = out_match_q;
	assign rsp.last        = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("fill count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n) pend_q |-> state_q == ST_SCAN)
		else $error("pending match outside a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		inval |-> (CW'(cmp_addr_s1) < rd_ptr_q) && (cmp_addr_s1 != head_idx_q))
		else $error("invalidation at an entry not yet passed or at the head");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_MATCH && DEPTH <= 64)
		|-> rsp.first_index < rsp.match_index)
		else $error("match index not after scanned entry");
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ddg_pkg::*;

	localparam int          TABLE_DEPTH  = DEPTH_DEF;
	localparam logic [1:0]  MODE_IGNORED = 2'd3;
	localparam int          TARGET_ITEMS = 410;
	localparam int          CALM_LEFT    = 50;
	localparam int          DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
	localparam int          SHOW_MAX     = 10;

	typedef struct packed {
		logic [1:0]        op;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		logic [IDX_W-1:0]  idx;
	} req_item_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] match_index;
		logic             last;
	} report_t;

	logic clk;
	logic arst_n;

	ddg_req_if req_ch ();
	ddg_rsp_if rsp_ch ();

	duplicate_digest_grouper dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	req_item_t request_queue[$];
	report_t   expected_reports[$];

	// shadow copy of the digest table
	logic [HALF_W-1:0] shadow_hi[TABLE_DEPTH];
	logic [HALF_W-1:0] shadow_lo[TABLE_DEPTH];
	logic              shadow_valid[TABLE_DEPTH];
	int                shadow_count;

	int        fail_count;
	int        shown_count;
	int        item_count;
	int        gap_left;
	int        stall_left;
	req_item_t live_item;
	report_t   got_report;
	report_t   want_report;

	function automatic logic [HALF_W-1:0] rand_half();
		return {$urandom, $urandom};
	endfunction

	function automatic void track_table(input req_item_t it);
		report_t r;
		report_t prev;
		bit      have_prev;
		int      head;
		have_prev = 0;
		case (it.op)
			MODE_APPEND: begin
				if (shadow_count >= TABLE_DEPTH) begin
					r.status      = STATUS_FULL;
					r.first_index = '0;
					r.match_index = '0;
					r.last        = 1'b1;
					expected_reports.push_back(r);
				end else begin
					shadow_hi[shadow_count]    = it.hi;
					shadow_lo[shadow_count]    = it.lo;
					shadow_valid[shadow_count] = 1'b1;
					shadow_count++;
				end
			end
			MODE_SCAN: begin
				head = int'(it.idx);
				if (head < shadow_count && shadow_valid[head]) begin
					for (int x = head + 1; x < shadow_count; x++) begin
						if (shadow_valid[x] && shadow_hi[x] == shadow_hi[head] &&
								shadow_lo[x] == shadow_lo[head]) begin
							if (have_prev)
								expected_reports.push_back(prev);
							prev.status      = STATUS_MATCH;
							prev.first_index = head[IDX_W-1:0];
							prev.match_index = x[IDX_W-1:0];
							prev.last        = 1'b0;
							have_prev        = 1;
							shadow_valid[x]  = 1'b0;
						end
					end
					// final match of the group carries the last flag
					if (have_prev) begin
						prev.last = 1'b1;
						expected_reports.push_back(prev);
					end
				end
			end
			MODE_CLEAR: begin
				for (int x = 0; x < TABLE_DEPTH; x++)
					shadow_valid[x] = 1'b0;
				shadow_count = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [HALF_W-1:0] hi,
			input logic [HALF_W-1:0] lo, input int unsigned idx);
		req_item_t it;
		it.op  = op;
		it.hi  = hi;
		it.lo  = lo;
		it.idx = idx[IDX_W-1:0];
		request_queue.push_back(it);
		if (op != MODE_IGNORED)
			item_count++;
	endtask

	task automatic build_stimulus();
		logic [HALF_W-1:0] a_hi;
		logic [HALF_W-1:0] a_lo;
		logic [HALF_W-1:0] pool_hi[4];
		logic [HALF_W-1:0] pool_lo[4];
		int                npool;
		int                fill;
		int                nscan;
		int                p;
		a_hi = rand_half();
		a_lo = rand_half();
		// zero digests, all-ones digests and near misses of one digest
		queue_item(MODE_APPEND, '0, '0, $urandom_range(0, 63));
		queue_item(MODE_APPEND, '1, '1, $urandom_range(0, 63));
		queue_item(MODE_APPEND, '0, '0, $urandom_range(0, 63));
		queue_item(MODE_APPEND, a_hi, a_lo, $urandom_range(0, 63));
		queue_item(MODE_APPEND, '1, '1, $urandom_range(0, 63));
		queue_item(MODE_APPEND, '0, '0, $urandom_range(0, 63));
		queue_item(MODE_APPEND, a_hi, a_lo ^ 64'd1, $urandom_range(0, 63));
		queue_item(MODE_APPEND, a_hi ^ {1'b1, 63'd0}, a_lo, $urandom_range(0, 63));
		queue_item(MODE_APPEND, a_hi, a_lo, $urandom_range(0, 63));
		queue_item(MODE_SCAN, rand_half(), rand_half(), 0);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 0);
		// entry 2 was invalidated by the first scan
		queue_item(MODE_SCAN, rand_half(), rand_half(), 2);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 1);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 3);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 8);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 9);
		queue_item(MODE_SCAN, rand_half(), rand_half(), 63);
		queue_item(MODE_IGNORED, rand_half(), rand_half(), $urandom_range(0, 63));
		queue_item(MODE_SCAN, rand_half(), rand_half(), 0);
		queue_item(MODE_CLEAR, rand_half(), rand_half(), $urandom_range(0, 63));
		queue_item(MODE_SCAN, rand_half(), rand_half(), 0);
		queue_item(MODE_APPEND, '1, '1, $urandom_range(0, 63));
		queue_item(MODE_APPEND, '1, '1, $urandom_range(0, 63));
		queue_item(MODE_SCAN, rand_half(), rand_half(), 0);
		queue_item(MODE_CLEAR, '1, '1, 63);

		// random part: fill a table from a small pool of digests, then scan it
		while (item_count < TARGET_ITEMS) begin
			queue_item(MODE_CLEAR, rand_half(), rand_half(), $urandom_range(0, 63));
			npool = $urandom_range(1, 4);
			for (int i = 0; i < 4; i++) begin
				pool_hi[i] = rand_half();
				pool_lo[i] = rand_half();
			end
			if ($urandom_range(0, 5) == 0) begin
				pool_hi[0] = '0;
				pool_lo[0] = '0;
			end
			fill = ($urandom_range(0, 5) == 0) ? TABLE_DEPTH : $urandom_range(1, 24);
			for (int i = 0; i < fill; i++) begin
				p = $urandom_range(0, npool - 1);
				if ($urandom_range(0, 3) != 0)
					queue_item(MODE_APPEND, pool_hi[p], pool_lo[p], $urandom_range(0, 63));
				else
					queue_item(MODE_APPEND, rand_half(), rand_half(), $urandom_range(0, 63));
			end
			if (fill == TABLE_DEPTH) begin
				for (int i = $urandom_range(1, 3); i > 0; i--)
					queue_item(MODE_APPEND, rand_half(), rand_half(), $urandom_range(0, 63));
			end
			nscan = $urandom_range(2, 8);
			for (int i = 0; i < nscan; i++) begin
				p = $urandom_range(0, npool - 1);
				if ($urandom_range(0, 5) == 0)
					queue_item(MODE_APPEND, pool_hi[p], pool_lo[p], $urandom_range(0, 63));
				else if ($urandom_range(0, 9) == 0)
					queue_item(MODE_SCAN, rand_half(), rand_half(), $urandom_range(0, 63));
				else
					queue_item(MODE_SCAN, rand_half(), rand_half(), $urandom_range(0, fill));
				if ($urandom_range(0, 7) == 0)
					queue_item(MODE_IGNORED, rand_half(), rand_half(), $urandom_range(0, 63));
			end
		end
	endtask

	// request driver with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.mode        <= '0;
			req_ch.digest_high <= '0;
			req_ch.digest_low  <= '0;
			req_ch.scan_index  <= '0;
			gap_left           <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				track_table(live_item);
			if (req_ch.valid && !req_ch.ready) begin
				// hold the current transaction
			end else if (gap_left > 0) begin
				gap_left     <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (request_queue.size() >= CALM_LEFT && $urandom_range(0, 5) == 0) begin
				gap_left     <= $urandom_range(0, 8);
				req_ch.valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				live_item           = request_queue.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.mode        <= live_item.op;
				req_ch.digest_high <= live_item.hi;
				req_ch.digest_low  <= live_item.lo;
				req_ch.scan_index  <= live_item.idx;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor with random backpressure bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_report.status      = rsp_ch.status;
				got_report.first_index = rsp_ch.first_index;
				got_report.match_index = rsp_ch.match_index;
				got_report.last        = rsp_ch.last;
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (shown_count < SHOW_MAX) begin
						shown_count++;
						$display("unexpected result: status %0d first %0d match %0d last %0d",
							got_report.status, got_report.first_index,
							got_report.match_index, got_report.last);
					end
				end else begin
					want_report = expected_reports.pop_front();
					if (want_report !== got_report) begin
						fail_count++;
						if (shown_count < SHOW_MAX) begin
							shown_count++;
							$display("mismatch: expected status %0d first %0d match %0d last %0d",
								want_report.status, want_report.first_index,
								want_report.match_index, want_report.last);
							$display("          actual   status %0d first %0d match %0d last %0d",
								got_report.status, got_report.first_index,
								got_report.match_index, got_report.last);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left   <= stall_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (request_queue.size() >= CALM_LEFT && $urandom_range(0, 4) == 0) begin
				stall_left   <= $urandom_range(0, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.mode        = '0;
		req_ch.digest_high = '0;
		req_ch.digest_low  = '0;
		req_ch.scan_index  = '0;
		rsp_ch.ready       = 1'b0;
		fail_count         = 0;
		shown_count        = 0;
		item_count         = 0;
		shadow_count       = 0;
		for (int x = 0; x < TABLE_DEPTH; x++) begin
			shadow_hi[x]    = '0;
			shadow_lo[x]    = '0;
			shadow_valid[x] = 1'b0;
		end
		build_stimulus();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (request_queue.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_reports.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
